@@ sv/rrpjs_pkg.sv @@
// ---------------------------------------------------------------------------
// rrpjs_pkg
// Shared types and constants of the round-robin priority job scheduler.
// ---------------------------------------------------------------------------
package rrpjs_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = IDX_W;
    localparam int CMP_W      = ((IDX_W > 4) ? IDX_W : 4) + 1;

    localparam logic [7:0] SLEEP_BIT = 8'h80;
    localparam logic [7:0] PRIO_MASK = 8'h7F;

    typedef enum logic [2:0] {
        CMD_SET   = 3'd0,
        CMD_SLEEP = 3'd1,
        CMD_WAKE  = 3'd2,
        CMD_END   = 3'd3,
        CMD_FIND  = 3'd4,
        CMD_SCHED = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    // one slot as it travels round the ring
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [7:0]       word;
    } t_slot;

    // write broadcast to every cell
    typedef struct packed {
        logic             en;
        t_cmd             op;
        logic [IDX_W-1:0] idx;
        logic [6:0]       prio;
    } t_cell_wr;

endpackage

@@ sv/round_robin_priority_job_scheduler_core.sv @@
// ---------------------------------------------------------------------------
// round_robin_priority_job_scheduler_core
// Priority job scheduler built as a rotating ring of slot cells.
// ---------------------------------------------------------------------------
// The slot table lives in a ring of SLOT_COUNT cells that rotates by one
// place every clock; each cell carries its slot number with its priority
// word. Set, sleep, wake and end are applied by the cell whose slot matches
// as the command is transferred in; the result then goes into the output
// register. Find-unused and schedule watch the head cell while the whole
// ring passes by, one slot per cycle, and then load the output register.
// One command is in progress at a time; a new one is accepted while the
// previous result still waits in the output register.
// ---------------------------------------------------------------------------
module round_robin_priority_job_scheduler_core
    import rrpjs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // [3:0] job_index, [10:4] prio_value, rest zero
    input  logic [2:0]  i_s_tuser,  // [2:0] command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // [3:0] result_index, rest zero
    output logic [0:0]  o_m_tuser   // [0] none_flag
);

    t_state            r_state;
    t_state            n_state;
    t_cmd              r_cmd;
    logic [CNT_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  r_s1;
    logic              r_found;
    logic [IDX_W-1:0]  r_best_idx;
    logic [IDX_W-1:0]  r_best_key;
    logic [6:0]        r_best_prio;
    logic [IDX_W-1:0]  r_cur_idx;
    logic              r_cur_idle;
    logic              r_out_valid;
    logic [3:0]        r_out_idx;
    logic              r_out_none;

    logic              s_acc;
    logic              scan_en;
    logic              emit_en;
    logic              out_free;
    t_cmd              in_cmd;
    logic [3:0]        in_job;
    logic [6:0]        in_prio;
    logic              slot_ok;
    t_cell_wr          cell_wr;
    t_slot             w_slot [SLOT_COUNT];

    t_slot             head;
    logic [IDX_W:0]    key_ext;
    logic [IDX_W-1:0]  key;
    logic              cand;
    logic              better;
    logic [IDX_W-1:0]  start;
    logic [3:0]        res_idx;
    logic              res_none;

    assign in_cmd  = t_cmd'(i_s_tuser);
    assign in_job  = i_s_tdata[3:0];
    assign in_prio = i_s_tdata[10:4];
    assign slot_ok = CMP_W'(in_job) < CMP_W'(SLOT_COUNT);
    assign s_acc   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    assign cell_wr.en   = s_acc && slot_ok;
    assign cell_wr.op   = in_cmd;
    assign cell_wr.idx  = IDX_W'(in_job);
    assign cell_wr.prio = in_prio;

    // ring of cells, head at cell 0
    for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_ring
        rrpjs_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_reset_idx (IDX_W'(k)),
            .i_prev      (w_slot[(k + 1) % SLOT_COUNT]),
            .i_wr        (cell_wr),
            .o_slot      (w_slot[k])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_state = (in_cmd == CMD_FIND || in_cmd == CMD_SCHED) ? S_SCAN : S_EMIT;
                end
            end
            S_SCAN: begin
                if (r_cnt == CNT_W'(SLOT_COUNT - 1)) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        scan_en    = 1'b0;
        emit_en    = 1'b0;
        unique case (r_state)
            S_IDLE:  o_s_tready = 1'b1;
            S_SCAN:  scan_en    = 1'b1;
            S_EMIT:  emit_en    = out_free;
            default: o_s_tready = 1'b0;
        endcase
    end

    // scan position of the head slot, counted from the slot after the start
    assign head    = w_slot[0];
    assign key_ext = ({1'b0, head.idx} >= {1'b0, r_s1})
                   ? ({1'b0, head.idx} - {1'b0, r_s1})
                   : ({1'b0, head.idx} + (IDX_W+1)'(SLOT_COUNT) - {1'b0, r_s1});
    assign key     = key_ext[IDX_W-1:0];

    always_comb begin
        cand   = 1'b0;
        better = 1'b0;
        if (r_cmd == CMD_FIND) begin
            cand   = (head.word == 8'h00);
            better = !r_found || (head.idx < r_best_idx);
        end else begin
            cand   = !head.word[7] && (head.word != 8'h00);
            better = !r_found || (head.word[6:0] > r_best_prio)
                   || ((head.word[6:0] == r_best_prio) && (key < r_best_key));
        end
    end

    assign start = r_cur_idle ? '0 : r_cur_idx;

    always_comb begin
        res_idx  = 4'd0;
        res_none = 1'b0;
        case (r_cmd) inside
            CMD_FIND, CMD_SCHED: begin
                res_idx  = r_found ? 4'(r_best_idx) : 4'd0;
                res_none = !r_found;
            end
            default: begin
                res_idx  = 4'd0;
                res_none = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_cur_idx   <= '0;
            r_cur_idle  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_acc) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
            end else if (scan_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (cand && better) r_found <= 1'b1;
            end
            if (emit_en) begin
                r_out_valid <= 1'b1;
                if (r_cmd == CMD_SCHED) begin
                    r_cur_idle <= !r_found;
                    if (r_found) r_cur_idx <= r_best_idx;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_IDLE && !s_acc) r_cnt <= '0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_cmd <= in_cmd;
            r_s1  <= (start == IDX_W'(SLOT_COUNT - 1)) ? '0 : start + IDX_W'(1);
        end
        if (scan_en && cand && better) begin
            r_best_idx  <= head.idx;
            r_best_key  <= key;
            r_best_prio <= head.word[6:0];
        end
        if (emit_en) begin
            r_out_idx  <= res_idx;
            r_out_none <= res_none;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = {4'd0, r_out_idx};
    assign o_m_tuser[0] = r_out_none;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_tready)
        else $error("command accepted while another is in progress");

    a_cnt_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt == '0))
        else $error("scan counter not cleared while idle");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt <= CNT_W'(SLOT_COUNT - 1)))
        else $error("scan counter past the last slot");

    a_sched_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_en && r_cmd == CMD_SCHED) |=> (r_cur_idle == r_out_none))
        else $error("current job does not match the schedule result");

endmodule

@@ sv/rrpjs_cell.sv @@
// ---------------------------------------------------------------------------
// rrpjs_cell
// One ring cell: takes its neighbour's slot every cycle and applies a write
// to it when the slot number matches.
// ---------------------------------------------------------------------------
module rrpjs_cell
    import rrpjs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_reset_idx,
    input  t_slot            i_prev,
    input  t_cell_wr         i_wr,
    output t_slot            o_slot
);

    t_slot r_slot;
    t_slot n_slot;

    always_comb begin
        n_slot = i_prev;
        if (i_wr.en && (i_prev.idx == i_wr.idx)) begin
            case (i_wr.op)
                CMD_SET:   n_slot.word = {1'b0, i_wr.prio};
                CMD_SLEEP: n_slot.word = i_prev.word | SLEEP_BIT;
                CMD_WAKE:  n_slot.word = i_prev.word & PRIO_MASK;
                CMD_END:   n_slot.word = 8'h00;
                default:   n_slot.word = i_prev.word;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.idx  <= i_reset_idx;
            r_slot.word <= 8'h00;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;

endmodule
